>>> sv/cc8_pkg.sv
// shared types and constants for the chacha8 keystream generator
`default_nettype none
package cc8_pkg;
  localparam int RESEED_INTERVAL = 16;
  localparam int DOUBLE_ROUNDS = 4;
  localparam int QR_STEPS = DOUBLE_ROUNDS * 8;
  localparam int QR_CNT_W = $clog2(QR_STEPS + 1);
  localparam int RSD_W = $clog2(RESEED_INTERVAL + 1);

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam logic REQ_RAW = 1'b0;
  localparam logic REQ_BOUNDED = 1'b1;

  localparam logic [1:0] CFG_KEY01 = 2'd0;
  localparam logic [1:0] CFG_KEY23 = 2'd1;
  localparam logic [1:0] CFG_KEY45 = 2'd2;
  localparam logic [1:0] CFG_KEY67 = 2'd3;

  // request and result payloads as carried on the two channels
  typedef struct packed {
    logic        req_type;
    logic [63:0] range_low;
    logic [63:0] range_high;
  } rng_request_t;

  typedef struct packed {
    logic [31:0] rand_word;
    logic [63:0] bounded_value;
    logic        empty_range;
  } rng_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINISH,
    ST_TAKE,
    ST_DIV,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch request fields
    logic blk_start;   // load round state from key and counter
    logic qr_step;     // run one quarter round
    logic blk_finish;  // add input back, update counters
    logic take_word;   // consume the next buffered word
    logic div_start;   // start the remainder unit
    logic out_load;    // fill output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_refill;
    logic rounds_done;
    logic empty;
    logic full_span;
    logic div_done;
    logic is_bounded;
  } stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction
endpackage
`default_nettype wire

>>> sv/cc8_stream_if.sv
// valid/ready channel carrying a payload
`default_nettype none
interface cc8_stream_if #(type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/cc8_ctrl.sv
// controller state machine sequencing refill, remainder and output
`default_nettype none
module cc8_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           reload,
  input  wire logic           in_fire,
  input  wire logic           out_free,
  input  wire cc8_pkg::stat_t stat,
  output cc8_pkg::cmd_t       cmd,
  output logic                busy
);
  cc8_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || reload) state_r <= cc8_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cc8_pkg::ST_IDLE: if (in_fire) state_nxt = cc8_pkg::ST_TAKE;
      cc8_pkg::ST_TAKE: begin
        if (stat.is_bounded && stat.empty) state_nxt = cc8_pkg::ST_OUT;
        else if (stat.need_refill) state_nxt = cc8_pkg::ST_ROUND;
        else if (stat.is_bounded && !stat.full_span) state_nxt = cc8_pkg::ST_DIV;
        else state_nxt = cc8_pkg::ST_OUT;
      end
      cc8_pkg::ST_ROUND: if (stat.rounds_done) state_nxt = cc8_pkg::ST_FINISH;
      cc8_pkg::ST_FINISH: state_nxt = cc8_pkg::ST_TAKE;
      cc8_pkg::ST_DIV: if (stat.div_done) state_nxt = cc8_pkg::ST_OUT;
      cc8_pkg::ST_OUT: if (out_free) state_nxt = cc8_pkg::ST_IDLE;
      default: state_nxt = cc8_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != cc8_pkg::ST_IDLE);
    case (state_r)
      cc8_pkg::ST_IDLE: cmd.capture = in_fire;
      cc8_pkg::ST_TAKE: begin
        if (!(stat.is_bounded && stat.empty)) begin
          if (stat.need_refill) cmd.blk_start = 1'b1;
          else begin
            cmd.take_word = 1'b1;
            cmd.div_start = stat.is_bounded && !stat.full_span;
          end
        end
      end
      cc8_pkg::ST_ROUND: cmd.qr_step = !stat.rounds_done;
      cc8_pkg::ST_FINISH: cmd.blk_finish = 1'b1;
      cc8_pkg::ST_DIV: cmd.out_load = 1'b0;
      cc8_pkg::ST_OUT: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end
endmodule
`default_nettype wire

>>> sv/cc8_datapath.sv
// keystream state, chacha quarter-round unit and remainder unit
`default_nettype none
module cc8_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          reload,
  input  wire logic [255:0]  key_init,
  input  wire cc8_pkg::cmd_t cmd,
  input  wire logic          req_type,
  input  wire logic [63:0]   range_low,
  input  wire logic [63:0]   range_high,
  output cc8_pkg::stat_t     stat,
  output logic [31:0]        word,
  output logic [63:0]        bounded,
  output logic               empty_flag
);
  logic [31:0] key_r [8];
  logic [31:0] blk_r [16];
  logic [31:0] w_r [16];
  logic [3:0]  ctr_r;
  logic [4:0]  ridx_r;
  logic        half_r;
  logic [cc8_pkg::RSD_W-1:0] rsd_r;
  logic [cc8_pkg::QR_CNT_W-1:0] qr_r;
  logic        type_r;
  logic [63:0] lo_r, span_r;
  logic        empty_r;
  logic [31:0] word_r;
  // remainder unit: restoring, one bit a cycle
  logic [63:0] rem_r;
  logic [31:0] quo_bits_r;
  logic [5:0]  dcnt_r;
  logic        dbusy_r;

  logic [63:0] span_c;
  logic [4:0]  usable;
  logic [31:0] init_w [16];
  logic [3:0]  qa, qb, qc, qd;
  logic [31:0] a1, d1, c1, b1, a2, d2, c2, b2;
  logic [2:0]  qsel;
  logic [64:0] rem_sh;
  logic [31:0] new_blk [16];
  logic [cc8_pkg::RSD_W-1:0] rsd_dec;

  assign span_c = range_high - range_low + 64'd1;
  assign usable = half_r ? 5'd8 : 5'd16;

  always_comb begin
    init_w[0] = cc8_pkg::SIGMA0;
    init_w[1] = cc8_pkg::SIGMA1;
    init_w[2] = cc8_pkg::SIGMA2;
    init_w[3] = cc8_pkg::SIGMA3;
    for (int i = 0; i < 8; i++) init_w[4+i] = key_r[i];
    init_w[12] = {28'd0, ctr_r};
    init_w[13] = '0; init_w[14] = '0; init_w[15] = '0;
    for (int i = 0; i < 16; i++) new_blk[i] = w_r[i] + init_w[i];
  end

  // quarter-round index selection: column then diagonal
  assign qsel = qr_r[2:0];
  always_comb begin
    case (qsel)
      3'd0: begin qa = 4'd0; qb = 4'd4; qc = 4'd8;  qd = 4'd12; end
      3'd1: begin qa = 4'd1; qb = 4'd5; qc = 4'd9;  qd = 4'd13; end
      3'd2: begin qa = 4'd2; qb = 4'd6; qc = 4'd10; qd = 4'd14; end
      3'd3: begin qa = 4'd3; qb = 4'd7; qc = 4'd11; qd = 4'd15; end
      3'd4: begin qa = 4'd0; qb = 4'd5; qc = 4'd10; qd = 4'd15; end
      3'd5: begin qa = 4'd1; qb = 4'd6; qc = 4'd11; qd = 4'd12; end
      3'd6: begin qa = 4'd2; qb = 4'd7; qc = 4'd8;  qd = 4'd13; end
      default: begin qa = 4'd3; qb = 4'd4; qc = 4'd9; qd = 4'd14; end
    endcase
    a1 = w_r[qa] + w_r[qb];
    d1 = cc8_pkg::rotl(w_r[qd] ^ a1, 16);
    c1 = w_r[qc] + d1;
    b1 = cc8_pkg::rotl(w_r[qb] ^ c1, 12);
    a2 = a1 + b1;
    d2 = cc8_pkg::rotl(d1 ^ a2, 8);
    c2 = c1 + d2;
    b2 = cc8_pkg::rotl(b1 ^ c2, 7);
  end

  assign rsd_dec = rsd_r - 1'b1;
  assign rem_sh = {rem_r, quo_bits_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n || reload) begin
      for (int i = 0; i < 8; i++) key_r[i] <= key_init[32*i +: 32];
      ctr_r <= '0;
      ridx_r <= 5'd16;
      half_r <= 1'b0;
      rsd_r <= cc8_pkg::RSD_W'(cc8_pkg::RESEED_INTERVAL);
      qr_r <= '0;
      dbusy_r <= 1'b0;
      dcnt_r <= '0;
    end else begin
      if (cmd.blk_start) begin
        for (int i = 0; i < 16; i++) w_r[i] <= init_w[i];
        qr_r <= '0;
      end
      if (cmd.qr_step) begin
        w_r[qa] <= a2; w_r[qb] <= b2; w_r[qc] <= c2; w_r[qd] <= d2;
        qr_r <= qr_r + 1'b1;
      end
      if (cmd.blk_finish) begin
        for (int i = 0; i < 16; i++) blk_r[i] <= new_blk[i];
        ridx_r <= '0;
        if (rsd_dec == '0) begin
          for (int i = 0; i < 8; i++) key_r[i] <= new_blk[8+i];
          half_r <= 1'b1;
          ctr_r <= '0;
          rsd_r <= cc8_pkg::RSD_W'(cc8_pkg::RESEED_INTERVAL);
        end else begin
          half_r <= 1'b0;
          ctr_r <= ctr_r + 1'b1;
          rsd_r <= rsd_dec;
        end
      end
      if (cmd.take_word) ridx_r <= ridx_r + 1'b1;
      if (cmd.div_start) begin
        dbusy_r <= 1'b1;
        dcnt_r <= '0;
      end else if (dbusy_r) begin
        dcnt_r <= dcnt_r + 1'b1;
        if (dcnt_r == 6'd31) dbusy_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_r <= req_type;
      lo_r <= range_low;
      span_r <= span_c;
      empty_r <= ($signed(range_low) > $signed(range_high));
      word_r <= '0;
    end
    if (cmd.take_word) begin
      word_r <= blk_r[ridx_r[3:0]];
      quo_bits_r <= blk_r[ridx_r[3:0]];
      rem_r <= '0;
    end else if (dbusy_r) begin
      quo_bits_r <= {quo_bits_r[30:0], 1'b0};
      if (rem_sh >= {1'b0, span_r}) rem_r <= 64'(rem_sh - {1'b0, span_r});
      else rem_r <= rem_sh[63:0];
    end
  end

  always_comb begin
    stat.need_refill = (ridx_r >= usable);
    stat.rounds_done = (qr_r == cc8_pkg::QR_CNT_W'(cc8_pkg::QR_STEPS));
    stat.empty = empty_r;
    stat.full_span = (span_r == '0);
    stat.div_done = dbusy_r && (dcnt_r == 6'd31);
    stat.is_bounded = (type_r == cc8_pkg::REQ_BOUNDED);
  end

  always_comb begin
    word = '0;
    bounded = '0;
    empty_flag = 1'b0;
    if (type_r == cc8_pkg::REQ_RAW) word = word_r;
    else if (empty_r) empty_flag = 1'b1;
    else begin
      word = word_r;
      bounded = (span_r == '0) ? lo_r + {32'd0, word_r} : lo_r + rem_r;
    end
  end
endmodule
`default_nettype wire

>>> sv/chacha8_keystream_rng.sv
// top level of the chacha8 keystream random number generator
// a request is served from a buffered word, after a block refill (32 quarter-round
//   steps) once the buffered words are used up, and through the bounded remainder unit
// when needed; one request at a time, the next taken once the result is loaded for output
// reset: synchronous active-low; key from key registers (zero), refill forced
// a key register write reloads the generator as reset does
`default_nettype none
module chacha8_keystream_rng (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cc8_stream_if.sink   in_req,
  cc8_stream_if.source out_res,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);
  logic [63:0] key_reg_r [4];
  logic        reload;
  cc8_pkg::cmd_t  cmd;
  cc8_pkg::stat_t stat;
  logic        busy;
  logic        in_fire;
  logic        out_valid_r;
  logic        out_free;
  logic [31:0] word;
  logic [63:0] bounded;
  logic        empty_flag;
  logic [31:0] word_r;
  logic [63:0] bounded_r;
  logic        empty_r;
  logic [255:0] key_init;

  // key registers; any write reloads
  assign reload = cfg_we;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_reg_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cc8_pkg::CFG_KEY01: key_reg_r[0] <= cfg_wdata;
        cc8_pkg::CFG_KEY23: key_reg_r[1] <= cfg_wdata;
        cc8_pkg::CFG_KEY45: key_reg_r[2] <= cfg_wdata;
        cc8_pkg::CFG_KEY67: key_reg_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // key value seen by the datapath includes a write in flight
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      key_init[64*i +: 64] = (cfg_we && cfg_index == 2'(i)) ? cfg_wdata : key_reg_r[i];
      if (!rst_n) key_init[64*i +: 64] = '0;
    end
  end

  assign in_req.ready = !busy;
  assign in_fire = in_req.valid && in_req.ready;
  // output register frees when empty or being taken
  assign out_free = !out_valid_r || out_res.ready;

  cc8_ctrl u_ctrl (
    .clk, .rst_n, .reload, .in_fire, .out_free, .stat, .cmd, .busy
  );

  cc8_datapath u_dp (
    .clk, .rst_n, .reload, .key_init, .cmd,
    .req_type(in_req.data.req_type),
    .range_low(in_req.data.range_low),
    .range_high(in_req.data.range_high),
    .stat, .word, .bounded, .empty_flag
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n || reload) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_res.ready) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      word_r <= word;
      bounded_r <= bounded;
      empty_r <= empty_flag;
    end
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data = cc8_pkg::rng_result_t'{word_r, bounded_r, empty_r};

  // ready only while idle, so never during a refill
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> !cmd.qr_step) else $error("ready during refill");
  // empty range never consumes a word
  a_empty_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.is_bounded && stat.empty) |-> !cmd.take_word) else $error("empty took word");
  // a loaded result is visible next cycle
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && !cfg_we) |=> out_res.valid) else $error("lost result");
endmodule
`default_nettype wire
